// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers. Expect clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/atr_pkg.sv
// ----------------------------------------------------------------------------
// atr_pkg
// Shared types and constants of the ADTS to RTP AAC repacker.
// ----------------------------------------------------------------------------
package atr_pkg;

  // Five entries keep the input at one byte per cycle, while the output does
  // not stall, through the four AU header beats at the start of every frame.
  localparam int QUEUE_DEPTH_DEF = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SEQ_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TS_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TS_STEP   = 2'd2;

  localparam logic [15:0] TS_STEP_RESET = 16'd1025;

  // Result kinds
  localparam logic [1:0] KIND_AU  = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
  localparam logic [3:0]  SYNC_NIBBLE  = 4'hF;
  localparam logic [7:0]  AU_LEN_HI    = 8'h00;
  localparam logic [7:0]  AU_LEN_LO    = 8'h10;
  localparam logic [12:0] ADTS_HDR_LEN = 13'd7;
  localparam logic [2:0]  HDR_LAST_IDX = 3'd6;
  localparam logic [1:0]  AU_LAST_BEAT = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALTED  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CMD_HDR = 2'd0,
    CMD_PAY = 2'd1,
    CMD_ERR = 2'd2
  } cmd_op_t;

  typedef struct packed {
    logic [12:0] frame_length;
    logic [1:0]  profile;
    logic [3:0]  rate_index;
    logic [2:0]  channel_config;
  } frame_info_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  data;
    logic        last;
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    frame_info_t info;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    frame_info_t info;
  } res_t;

endpackage

// File: hdl/atr_ifs.sv
// ----------------------------------------------------------------------------
// atr_ifs
// Valid/ready channels of the repacker: byte input, results, register writes.
// ----------------------------------------------------------------------------
interface atr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface atr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic        last;
  logic [15:0] sequence_res;
  logic [31:0] timestamp;
  logic [12:0] frame_length;
  logic [1:0]  profile;
  logic [3:0]  rate_index;
  logic [2:0]  channel_config;

  modport source (output valid, output kind, output data, output last,
                  output sequence_res, output timestamp, output frame_length,
                  output profile, output rate_index, output channel_config,
                  input ready);
  modport sink   (input valid, input kind, input data, input last,
                  input sequence_res, input timestamp, input frame_length,
                  input profile, input rate_index, input channel_config,
                  output ready);
endinterface

interface atr_cfg_if;
  import atr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: hdl/atr_queue.sv
// ----------------------------------------------------------------------------
// atr_queue
// Small command FIFO between the header parser and the result emitter.
// ----------------------------------------------------------------------------
module atr_queue #(
  parameter int DEPTH = atr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  atr_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output atr_pkg::cmd_t  head_cmd,
  output logic           empty
);
  import atr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hdl/atr_front.sv
// ----------------------------------------------------------------------------
// atr_front
// Collects ADTS headers, checks sync and length, tracks payload bytes and the
// per-frame counters, and queues one command per result group.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atr_front (
  input  logic          clk,
  input  logic          rst_n,
  atr_in_if.sink        in_if,
  atr_cfg_if.sink       cfg_if,
  output logic          push,
  output atr_pkg::cmd_t push_cmd,
  input  logic          q_full
);
  import atr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hcnt_r;
  logic [47:0] hdr_r;          // previous six header bytes, oldest on top
  logic [12:0] rem_r;
  frame_info_t info_r;
  logic [15:0] seq_r;
  logic [31:0] ts_r;
  logic [15:0] step_r;
  logic        any_done_r;

  logic [7:0]  h0, h1, h2, h3, h4, h5;
  logic        sync_ok, len_ok, hdr_done, last_byte, accept, cfg_wr, frame_end;
  frame_info_t parsed;

  assign h0 = hdr_r[47:40];
  assign h1 = hdr_r[39:32];
  assign h2 = hdr_r[31:24];
  assign h3 = hdr_r[23:16];
  assign h4 = hdr_r[15:8];
  assign h5 = hdr_r[7:0];

  always_comb begin
    parsed.profile        = h2[7:6];
    parsed.rate_index     = h2[5:2];
    parsed.channel_config = {h2[0], h3[7:6]};
    parsed.frame_length   = {h3[1:0], h4, h5[7:5]};
  end

  assign sync_ok   = (h0 == SYNC_BYTE) && (h1[7:4] == SYNC_NIBBLE);
  assign len_ok    = (parsed.frame_length > ADTS_HDR_LEN);
  assign in_if.ready = (phase_r == PH_HALTED) || !q_full;
  assign accept    = in_if.valid & in_if.ready;
  assign hdr_done  = (hcnt_r == HDR_LAST_IDX);
  assign last_byte = (rem_r == 13'd1);
  assign frame_end = accept && (phase_r == PH_PAYLOAD) && last_byte;
  assign cfg_if.ready = 1'b1;
  assign cfg_wr    = cfg_if.valid;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (accept && hdr_done) begin
          phase_nxt = (sync_ok && len_ok) ? PH_PAYLOAD : PH_HALTED;
        end
      end
      PH_PAYLOAD: begin
        if (accept && last_byte) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_HALTED: phase_nxt = PH_HALTED;
      default:   phase_nxt = PH_HEADER;
    endcase
  end

  // command generation
  always_comb begin
    push                  = 1'b0;
    push_cmd.op           = CMD_PAY;
    push_cmd.data         = in_if.byte_in;
    push_cmd.last         = 1'b0;
    push_cmd.sequence_res = seq_r;
    push_cmd.timestamp    = ts_r;
    push_cmd.info         = info_r;
    unique case (phase_r)
      PH_HEADER: begin
        push = accept && hdr_done;
        if (!sync_ok) begin
          push_cmd.op   = CMD_ERR;
          push_cmd.info = '0;
        end else if (!len_ok) begin
          push_cmd.op   = CMD_ERR;
          push_cmd.info = parsed;
        end else begin
          push_cmd.op   = CMD_HDR;
          push_cmd.info = parsed;
        end
      end
      PH_PAYLOAD: begin
        push          = accept;
        push_cmd.last = last_byte;
      end
      PH_HALTED: push = 1'b0;
      default:   push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hcnt_r     <= '0;
      seq_r      <= '0;
      ts_r       <= '0;
      step_r     <= TS_STEP_RESET;
      any_done_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (accept && phase_r == PH_HEADER) begin
        hcnt_r <= hdr_done ? '0 : hcnt_r + 1'b1;
      end
      if (frame_end) begin
        seq_r      <= seq_r + 16'd1;
        ts_r       <= ts_r + {16'd0, step_r};
        any_done_r <= 1'b1;
      end
      // start registers load the counters only before the first frame ends
      if (cfg_wr) begin
        unique case (cfg_if.index)
          REG_SEQ_START: if (!any_done_r && !frame_end) seq_r <= cfg_if.wdata[15:0];
          REG_TS_START:  if (!any_done_r && !frame_end) ts_r <= cfg_if.wdata;
          REG_TS_STEP:   step_r <= cfg_if.wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_HEADER) begin
      hdr_r <= {hdr_r[39:0], in_if.byte_in};
      if (hdr_done) begin
        info_r <= sync_ok ? parsed : '0;
        rem_r  <= parsed.frame_length - ADTS_HDR_LEN;
      end
    end else if (accept && phase_r == PH_PAYLOAD) begin
      rem_r <= rem_r - 13'd1;
    end
  end

  `ASSERT_NEXT(a_halt_sticks, phase_r == PH_HALTED, phase_r == PH_HALTED,
               "repacker left halted state without reset")
  `ASSERT_IMPL(a_rem_nonzero, phase_r == PH_PAYLOAD, rem_r != 13'd0,
               "payload phase with no bytes remaining")
  `ASSERT_IMPL(a_no_push_full, push, !q_full,
               "command pushed into full queue")

endmodule

// File: hdl/atr_back.sv
// ----------------------------------------------------------------------------
// atr_back
// Expands queued commands into result transfers through an output register:
// four AU header bytes per frame, payload bytes one for one, error results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  atr_pkg::cmd_t head_cmd,
  input  logic          q_empty,
  output logic          pop,
  atr_out_if.source     out_if
);
  import atr_pkg::*;

  logic        out_valid_r;
  res_t        res_r, res_nxt;
  logic [1:0]  beat_r;
  logic        load_en, take;
  logic [12:0] size;

  assign load_en = !out_valid_r || out_if.ready;
  assign take    = load_en && !q_empty;
  assign size    = head_cmd.info.frame_length - ADTS_HDR_LEN;
  assign pop     = take && ((head_cmd.op != CMD_HDR) || (beat_r == AU_LAST_BEAT));

  always_comb begin
    res_nxt.sequence_res = head_cmd.sequence_res;
    res_nxt.timestamp    = head_cmd.timestamp;
    res_nxt.info         = head_cmd.info;
    res_nxt.kind         = KIND_PAY;
    res_nxt.data         = head_cmd.data;
    res_nxt.last         = head_cmd.last;
    unique case (head_cmd.op)
      CMD_HDR: begin
        res_nxt.kind = KIND_AU;
        res_nxt.last = 1'b0;
        unique case (beat_r)
          2'd0:    res_nxt.data = AU_LEN_HI;
          2'd1:    res_nxt.data = AU_LEN_LO;
          2'd2:    res_nxt.data = size[12:5];
          default: res_nxt.data = {size[4:0], 3'b000};
        endcase
      end
      CMD_PAY: res_nxt.kind = KIND_PAY;
      CMD_ERR: begin
        res_nxt.kind = KIND_ERR;
        res_nxt.data = '0;
        res_nxt.last = 1'b1;
      end
      default: res_nxt.kind = KIND_ERR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= '0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        beat_r      <= pop ? '0 : beat_r + 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = res_r.kind;
  assign out_if.data           = res_r.data;
  assign out_if.last           = res_r.last;
  assign out_if.sequence_res   = res_r.sequence_res;
  assign out_if.timestamp      = res_r.timestamp;
  assign out_if.frame_length   = res_r.info.frame_length;
  assign out_if.profile        = res_r.info.profile;
  assign out_if.rate_index     = res_r.info.rate_index;
  assign out_if.channel_config = res_r.info.channel_config;

  `ASSERT_IMPL(a_beat_hdr_only, beat_r != 2'd0, !q_empty && head_cmd.op == CMD_HDR,
               "AU header beat in progress without header command")
  `ASSERT_NEXT(a_take_valid, take, out_valid_r,
               "loaded result not presented")
  `ASSERT_NEXT(a_stall_holds, out_valid_r && !out_if.ready, out_valid_r,
               "stalled result dropped")

endmodule

// File: hdl/adts_to_rtp_aac_repacker_unit.sv
// ----------------------------------------------------------------------------
// adts_to_rtp_aac_repacker_unit
// ADTS AAC byte stream to RFC 3640 AU header plus payload byte stream.
// ----------------------------------------------------------------------------
// The unit takes one stream byte per cycle while its command queue has room.
// The seventh header byte of a good frame yields four AU header result
// transfers; every payload byte yields one result. A byte's command is
// written to the command queue, and its first result is then loaded into
// the output register, which presents it on the output. Sustained input
// rate is one byte per cycle while the output does not stall: the four AU
// header beats are absorbed by the queue (QUEUE_DEPTH entries, at least five
// needed) and drained during the seven header bytes of the next frame. After
// a sync or length error one error result is produced and further bytes are
// accepted and discarded until reset. Register writes are always accepted;
// the start registers load the counters only before the first frame ends.
module adts_to_rtp_aac_repacker_unit #(
  parameter int QUEUE_DEPTH = atr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  atr_in_if.sink    in_if,
  atr_out_if.source out_if,
  atr_cfg_if.sink   cfg_if
);
  import atr_pkg::*;

  logic push, q_full, pop, q_empty;
  cmd_t push_cmd, head_cmd;

  atr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg_if   (cfg_if),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  atr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  atr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_if   (out_if)
  );

endmodule
